// ===== design/spr_pkg.sv =====
// Shared types and constants for the stream pattern replace block.
// Used by spr_front, spr_queue, spr_back and the top level; no dependencies.
package spr_pkg;

  // Longest pattern and replacement held by the block
  localparam int MAX_PATTERN     = 16;
  localparam int MAX_REPLACEMENT = 16;

  // Bytes carried by one command, and widths that follow from it
  localparam int CMD_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CNT_W     = $clog2(CMD_BYTES + 1);
  localparam int IDX_W     = $clog2(CMD_BYTES);

  // Configuration register widths
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // A pattern that starts with this byte never matches
  localparam logic [7:0] NEWLINE_BYTE = 8'h0a;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW        = 3'd0,
    REG_PATTERN_HIGH       = 3'd1,
    REG_PATTERN_LENGTH     = 3'd2,
    REG_REPLACEMENT_LOW    = 3'd3,
    REG_REPLACEMENT_HIGH   = 3'd4,
    REG_REPLACEMENT_LENGTH = 3'd5
  } cfg_reg_t;

  // One emit command: up to CMD_BYTES bytes, a byte count and the end-of-stream flag.
  // A count of zero with fin set stands for a bare end-of-stream marker.
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] data;
    logic [CNT_W-1:0]          count;
    logic                      fin;
  } cmd_t;

endpackage

// ===== design/spr_front.sv =====
// Front end: configuration registers, match window and per-byte classification.
// Turns each accepted byte into at most one emit command for the queue. Uses spr_pkg.
module spr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_final,
  input  logic                          q_full,
  output logic                          push,
  output spr_pkg::cmd_t                 push_cmd
);
  import spr_pkg::*;

  logic [63:0]      pattern_low, pattern_high;
  logic [63:0]      replacement_low, replacement_high;
  logic [LEN_W-1:0] pattern_length, replacement_length;

  logic [MAX_PATTERN-1:0][7:0] window, window_next;
  logic [LEN_W-1:0]            fill, fill_next;

  logic [15:0][7:0]            pat_bytes, rep_bytes;
  logic [LEN_W-1:0]            plen, rlen, fill_eff, fill_inc;
  logic [MAX_PATTERN-1:0][7:0] w_app;
  logic                        full, equal, match, accept;
  cmd_t                        cmd;

  assign pat_bytes = {pattern_high, pattern_low};
  assign rep_bytes = {replacement_high, replacement_low};

  // Clamp lengths to what the block holds
  assign plen = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern_length;
  assign rlen = (replacement_length > LEN_W'(MAX_REPLACEMENT)) ?
                LEN_W'(MAX_REPLACEMENT) : replacement_length;

  // Restart the window if it already holds the pattern length or more
  assign fill_eff = (fill >= plen) ? '0 : fill;
  assign fill_inc = LEN_W'(fill_eff + LEN_W'(1));
  assign full     = (fill_inc == plen);

  // Window with the new byte appended
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w_app[i] = (LEN_W'(i) == fill_eff) ? in_byte : window[i];
    end
  end

  // Compare the appended window against the pattern
  always_comb begin
    equal = (pat_bytes[0] != NEWLINE_BYTE);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < plen) && (w_app[i] != pat_bytes[i])) begin
        equal = 1'b0;
      end
    end
  end

  assign match = (plen != '0) && full && equal;

  // Build the command and the next window state
  always_comb begin
    cmd         = '0;
    cmd.fin     = in_final;
    window_next = window;
    fill_next   = fill_eff;
    if (plen == '0) begin
      cmd.data[0] = in_byte;
      cmd.count   = CNT_W'(1);
      fill_next   = '0;
    end else if (match) begin
      for (int i = 0; i < MAX_REPLACEMENT; i++) begin
        cmd.data[i] = rep_bytes[i];
      end
      cmd.count = CNT_W'(rlen);
      fill_next = '0;
    end else if (full) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        cmd.data[i] = w_app[i];
      end
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        window_next[i] = w_app[i + 1];
      end
      cmd.count = in_final ? CNT_W'(plen) : CNT_W'(1);
      fill_next = LEN_W'(plen - LEN_W'(1));
    end else begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        cmd.data[i] = w_app[i];
      end
      window_next = w_app;
      cmd.count   = in_final ? CNT_W'(fill_inc) : '0;
      fill_next   = fill_inc;
    end
    if (in_final) begin
      fill_next = '0;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && ((cmd.count != '0) || in_final);
  assign push_cmd = cmd;

  // Hold configuration and window fill
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low        <= '0;
      pattern_high       <= '0;
      pattern_length     <= '0;
      replacement_low    <= '0;
      replacement_high   <= '0;
      replacement_length <= '0;
      fill               <= '0;
    end else begin
      if (accept) begin
        fill <= fill_next;
      end
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PATTERN_LOW:        pattern_low  <= cfg_data;
          REG_PATTERN_HIGH:       pattern_high <= cfg_data;
          REG_PATTERN_LENGTH: begin
            pattern_length <= cfg_data[LEN_W-1:0];
            fill           <= '0;
          end
          REG_REPLACEMENT_LOW:    replacement_low    <= cfg_data;
          REG_REPLACEMENT_HIGH:   replacement_high   <= cfg_data;
          REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Advance window contents
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

// ===== design/spr_queue.sv =====
// Short command queue between front and back ends.
// Register-based FIFO of spr_pkg::cmd_t entries. Uses spr_pkg.
module spr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output spr_pkg::cmd_t pop_cmd
);
  import spr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_cmd  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + PTR_W'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + PTR_W'(1));
      end
      priority if (push && !pop) begin
        count <= QCNT_W'(count + QCNT_W'(1));
      end else if (pop && !push) begin
        count <= QCNT_W'(count - QCNT_W'(1));
      end else begin
        count <= count;
      end
    end
  end

  // Store pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== design/spr_back.sv =====
// Back end: serializes emit commands into result transfers, one per cycle unless result_ready stalls.
// Holds the current command and the output register. Uses spr_pkg.
module spr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_nonempty,
  input  spr_pkg::cmd_t pop_cmd,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_ready,
  output logic [7:0]    out_byte,
  output logic          out_valid,
  output logic          run_last,
  output logic          stream_end
);
  import spr_pkg::*;

  cmd_t             cur;
  logic             cur_busy;
  logic [IDX_W-1:0] idx, last_idx;
  logic             advance, at_last, cur_done, load;

  assign advance  = !result_valid || result_ready;
  assign last_idx = (cur.count == '0) ? '0 : IDX_W'(cur.count - CNT_W'(1));
  assign at_last  = (idx == last_idx);
  assign cur_done = cur_busy && advance && at_last;
  assign load     = q_nonempty && (!cur_busy || cur_done);
  assign pop      = load;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_busy     <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= cur_busy;
      end
      priority if (load) begin
        cur_busy <= 1'b1;
        idx      <= '0;
      end else if (cur_done) begin
        cur_busy <= 1'b0;
      end else if (cur_busy && advance) begin
        idx <= IDX_W'(idx + IDX_W'(1));
      end else begin
        idx <= idx;
      end
    end
  end

  // Load command and drive output payload
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pop_cmd;
    end
    if (advance && cur_busy) begin
      out_byte   <= (cur.count == '0) ? 8'h00 : cur.data[idx];
      out_valid  <= (cur.count != '0);
      run_last   <= at_last;
      stream_end <= cur.fin && at_last;
    end
  end

endmodule

// ===== design/stream_pattern_replace_top.sv =====
// Top level of the stream pattern replace block.
// Instantiates spr_front, spr_queue and spr_back; uses spr_pkg.
//
// Usage:
//   Bytes enter on in_valid/in_ready with in_byte and in_final; results leave on
//   result_valid/result_ready with out_byte, out_valid, run_last and stream_end.
//   Each non-overlapping occurrence of the pattern is replaced by the replacement;
//   in_final flushes the bytes held in the window and closes the stream.
//   Configuration goes through cfg_write/cfg_index/cfg_data while the block is idle;
//   writing the pattern length empties the window.
// Path: a byte's first result passes the command queue, cur and the output register.
// Throughput: one input byte per cycle while result_ready is high and each byte
//   causes at most one result. A byte with more results holds the output serializer
//   until they are out; the two-entry queue fills and in_ready drops until it drains.
// Reset: synchronous rst clears the configuration and empties the window and queue.
// Stall: when result_ready is low the output register holds its result; the front
//   keeps accepting bytes until the command queue is full.
module stream_pattern_replace_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           in_final,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_valid,
  output logic                           run_last,
  output logic                           stream_end
);
  import spr_pkg::*;

  logic q_full, q_nonempty, push, pop;
  cmd_t push_cmd, pop_cmd;

  // Classify bytes and build commands
  spr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_final  (in_final),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Decouple front from back
  spr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .pop_cmd  (pop_cmd)
  );

  // Serialize commands into result transfers
  spr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .pop_cmd      (pop_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .run_last     (run_last),
    .stream_end   (stream_end)
  );

endmodule

// ===== dv/stream_pattern_replace_top_test.sv =====
// Self-checking testbench for stream_pattern_replace_top: find-and-replace on a byte stream.
// Predicts every output byte in SystemVerilog and scoreboards the result channel.
// Depends on spr_pkg and the RTL under design/.
`timescale 1ns / 1ps

module stream_pattern_replace_top_test;
  import spr_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT  = 50;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       stream_end;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } src_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_byte = '0;
  logic                  in_final = 1'b0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [7:0]            out_byte;
  logic                  out_valid;
  logic                  run_last;
  logic                  stream_end;

  stream_pattern_replace_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_final     (in_final),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .run_last     (run_last),
    .stream_end   (stream_end)
  );

  // Predictor copy of the configuration and the match window
  logic [63:0] pat_lo = '0, pat_hi = '0, rep_lo = '0, rep_hi = '0;
  logic [4:0]  pat_len = '0, rep_len = '0;
  logic [7:0]  window_buf [MAX_PATTERN];
  int          window_fill = 0;

  src_item_t src_q [$];
  result_t   emitted_q [$];
  int        items_queued = 0;
  int        items_taken = 0;
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_req = 1'b0;
  int        hold_cnt = 0;
  result_t   head_result;
  src_item_t next_item;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (window_buf[i]) window_buf[i] = '0;
  end

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (error_count < PRINT_LIMIT)
      $display("tb: mismatch on %s: got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic logic [7:0] pat_byte(int i);
    if (i < 8) return pat_lo[8*i +: 8];
    return pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] rep_byte(int i);
    if (i < 8) return rep_lo[8*i +: 8];
    return rep_hi[8*(i-8) +: 8];
  endfunction

  function automatic int eff_plen();
    return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
  endfunction

  function automatic int eff_rlen();
    return (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(rep_len);
  endfunction

  // A pattern that leads with a newline never matches
  function automatic bit window_hit(int len);
    if (pat_byte(0) == NEWLINE_BYTE) return 1'b0;
    for (int i = 0; i < len; i++)
      if (window_buf[i] != pat_byte(i)) return 1'b0;
    return 1'b1;
  endfunction

  // Compute the output bytes caused by one accepted input byte
  task automatic replace_byte(logic [7:0] b, logic fin);
    result_t outs [$];
    int pl, rl;
    pl = eff_plen();
    rl = eff_rlen();
    if (pl == 0) begin
      window_fill = 0;
      outs.push_back('{b, 1'b1, 1'b0, 1'b0});
    end else begin
      if (window_fill >= pl) window_fill = 0;
      window_buf[window_fill] = b;
      window_fill++;
      if (window_fill == pl) begin
        if (window_hit(pl)) begin
          for (int i = 0; i < rl; i++) outs.push_back('{rep_byte(i), 1'b1, 1'b0, 1'b0});
          window_fill = 0;
        end else begin
          outs.push_back('{window_buf[0], 1'b1, 1'b0, 1'b0});
          for (int i = 1; i < window_fill; i++) window_buf[i-1] = window_buf[i];
          window_fill--;
        end
      end
    end
    // Flush the window at end of stream; mark an empty end with a bare result
    if (fin) begin
      for (int i = 0; i < window_fill; i++) outs.push_back('{window_buf[i], 1'b1, 1'b0, 1'b0});
      window_fill = 0;
      if (outs.size() == 0) outs.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
    end
    if (outs.size() > 0) begin
      outs[outs.size()-1].run_last = 1'b1;
      if (fin) outs[outs.size()-1].stream_end = 1'b1;
    end
    foreach (outs[i]) emitted_q.push_back(outs[i]);
  endtask

  // Driver: advance to the next pending byte once the current one is transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        replace_byte(in_byte, in_final);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (src_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = src_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= next_item.data;
          in_final <= next_item.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count the cycles of the long receiver hold-off
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Monitor: check each result transfer against the oldest predicted byte
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (emitted_q.size() == 0) begin
          report_mismatch("unexpected result", out_byte, 8'h00);
        end else begin
          head_result = emitted_q.pop_front();
          if (out_byte !== head_result.data)
            report_mismatch("out_byte", out_byte, head_result.data);
          if (out_valid !== head_result.valid)
            report_mismatch("out_valid", out_valid, head_result.valid);
          if (run_last !== head_result.run_last)
            report_mismatch("run_last", run_last, head_result.run_last);
          if (stream_end !== head_result.stream_end)
            report_mismatch("stream_end", stream_end, head_result.stream_end);
        end
      end
      // Hold off for a long stretch once asked, else stall at random
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default:   begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  task automatic push_item(logic [7:0] b, logic fin);
    src_q.push_back('{b, fin});
    items_queued++;
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PATTERN_LOW:     pat_lo = val;
      REG_PATTERN_HIGH:    pat_hi = val;
      REG_PATTERN_LENGTH:  begin pat_len = val[4:0]; window_fill = 0; end
      REG_REPLACEMENT_LOW: rep_lo = val;
      REG_REPLACEMENT_HIGH: rep_hi = val;
      default:             rep_len = val[4:0];
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_config(logic [63:0] plo, logic [63:0] phi, logic [4:0] plen,
                             logic [63:0] rlo, logic [63:0] rhi, logic [4:0] rlen);
    write_reg(REG_PATTERN_LOW, plo);
    write_reg(REG_PATTERN_HIGH, phi);
    write_reg(REG_PATTERN_LENGTH, {59'd0, plen});
    write_reg(REG_REPLACEMENT_LOW, rlo);
    write_reg(REG_REPLACEMENT_HIGH, rhi);
    write_reg(REG_REPLACEMENT_LENGTH, {59'd0, rlen});
    close_writes();
  endtask

  function automatic logic [63:0] rand_data();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] rand_len();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       v[4:0] = 5'd0;
      1:       v[4:0] = 5'd1;
      2:       v[4:0] = 5'd2;
      3:       v[4:0] = 5'd16;
      4:       v[4:0] = 5'd31;
      5:       v[4:0] = 5'($urandom_range(31));
      default: v[4:0] = 5'($urandom_range(8, 3));
    endcase
    return v;
  endfunction

  // Rewrite all registers or a random subset; a pattern length write empties the window
  task automatic reconfigure(bit all);
    logic [63:0] v;
    if (all || $urandom_range(1)) begin
      v = rand_data();
      if ($urandom_range(7) == 0) v[7:0] = NEWLINE_BYTE;
      write_reg(REG_PATTERN_LOW, v);
    end
    if (all || $urandom_range(1)) write_reg(REG_PATTERN_HIGH, rand_data());
    if (all || $urandom_range(1)) write_reg(REG_PATTERN_LENGTH, rand_len());
    if (all || $urandom_range(1)) write_reg(REG_REPLACEMENT_LOW, rand_data());
    if (all || $urandom_range(1)) write_reg(REG_REPLACEMENT_HIGH, rand_data());
    if (all || $urandom_range(1)) write_reg(REG_REPLACEMENT_LENGTH, rand_len());
    close_writes();
  endtask

  // About half the picks are pattern copies, the rest single bytes; some copies cut short or corrupted
  task automatic gen_stream(int count);
    int pl, sel, cut, bad, n;
    logic [7:0] b;
    pl = eff_plen();
    n = 0;
    while (n < count) begin
      sel = $urandom_range(99);
      if (pl > 0 && sel < 50) begin
        cut = ($urandom_range(9) == 0) ? $urandom_range(pl - 1) : pl;
        bad = ($urandom_range(9) == 0) ? $urandom_range(pl - 1) : -1;
        for (int j = 0; j < cut && n < count; j++) begin
          b = pat_byte(j);
          if (j == bad) b = b ^ 8'($urandom_range(255, 1));
          push_item(b, $urandom_range(15) == 0);
          n++;
        end
      end else begin
        if (pl > 0 && sel < 75) b = pat_byte($urandom_range(pl - 1));
        else b = 8'($urandom_range(255));
        push_item(b, $urandom_range(15) == 0);
        n++;
      end
    end
  endtask

  // Wait until every byte is transferred and every result has come back
  task automatic wait_idle();
    while (items_taken != items_queued || emitted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [63:0] plo;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_idle(IDLE_NONE);

    // Pass-through with the reset configuration
    push_item(8'h00, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(8'h80, 1'b1);
    wait_idle();

    // Two-byte pattern removed; last match on the final byte leaves a bare end marker
    load_config(64'h6261, '0, 5'd2, '0, '0, 5'd0);
    push_item(8'h61, 1'b0);
    push_item(8'h62, 1'b0);
    push_item(8'h62, 1'b0);
    push_item(8'h61, 1'b0);
    push_item(8'h62, 1'b1);
    wait_idle();

    // Newline-led pattern never matches
    load_config(64'h0a, '0, 5'd1, 64'h5a5a, '0, 5'd2);
    push_item(NEWLINE_BYTE, 1'b0);
    push_item(NEWLINE_BYTE, 1'b1);
    wait_idle();

    // Oversized lengths clamp to a full sixteen-byte pattern and replacement
    plo = {$urandom, $urandom};
    plo[7:0] = 8'h11;
    load_config(plo, {$urandom, $urandom}, 5'd31, {$urandom, $urandom},
                {$urandom, $urandom}, 5'd31);
    for (int j = 0; j < MAX_PATTERN; j++) push_item(pat_byte(j), j == MAX_PATTERN - 1);
    wait_idle();

    // Long receiver hold-off with a steady sender and sixteen bytes out per byte in
    load_config(64'h71, '0, 5'd1, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
    hold_req = 1'b1;
    for (int j = 0; j < 40; j++) push_item(8'h71, j == 39);
    wait_idle();

    // Random phases, rotating through the idle modes
    for (int ph = 0; ph < 10; ph++) begin
      set_idle(idle_mode_t'(ph % 4));
      reconfigure(ph == 0 || $urandom_range(2) == 0);
      gen_stream(19);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout guard
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
design/spr_pkg.sv
design/spr_front.sv
design/spr_queue.sv
design/spr_back.sv
design/stream_pattern_replace_top.sv
dv/stream_pattern_replace_top_test.sv
